>>> rtl/xed_pkg.sv
// Shared constants, types and lookup functions for the XML entity decoder.
// No dependencies; xed_cp_unit, xed_out_stage and xml_entity_decoder import this package.
`default_nettype none

package xed_pkg;

  localparam int unsigned MAX_REF_CHARS = 12;
  localparam int unsigned CNT_W         = $clog2(MAX_REF_CHARS + 1);
  localparam int unsigned IDX_W         = $clog2(MAX_REF_CHARS);
  localparam int unsigned CP_W          = 21;
  localparam int unsigned LIM_W         = 16;
  localparam int unsigned NUM_ENT       = 5;

  localparam logic [CP_W-1:0]  CP_MAX    = 21'h1FFFFF;
  localparam logic [LIM_W-1:0] LIMIT_RST = 16'hFFFF;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UX   = 8'h58;

  localparam logic [2:0] ENT_AMP  = 3'd0;
  localparam logic [2:0] ENT_LT   = 3'd1;
  localparam logic [2:0] ENT_GT   = 3'd2;
  localparam logic [2:0] ENT_QUOT = 3'd3;
  localparam logic [2:0] ENT_APOS = 3'd4;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_NAMED,
    MD_HASH,
    MD_HEXMARK,
    MD_DEC,
    MD_HEX
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FLUSH,
    ST_AFRESH,
    ST_UTF,
    ST_TERM,
    ST_FIN
  } state_e;

  // request from the sequencer to the output stage
  typedef struct packed {
    logic       push;
    logic       fin;
    logic [7:0] data;
    logic       term;
  } res_req_t;

  // byte pos of a named entity's text, first byte at index 0
  function automatic logic [7:0] ent_byte(input logic [2:0] e, input logic [2:0] pos);
    logic [5:0][7:0] txt;
    logic [7:0]      r;
    case (e)
      ENT_AMP:  txt = {8'h00, 8'h3B, 8'h70, 8'h6D, 8'h61, 8'h26};
      ENT_LT:   txt = {8'h00, 8'h00, 8'h3B, 8'h74, 8'h6C, 8'h26};
      ENT_GT:   txt = {8'h00, 8'h00, 8'h3B, 8'h74, 8'h67, 8'h26};
      ENT_QUOT: txt = {8'h3B, 8'h74, 8'h6F, 8'h75, 8'h71, 8'h26};
      ENT_APOS: txt = {8'h3B, 8'h73, 8'h6F, 8'h70, 8'h61, 8'h26};
      default:  txt = '0;
    endcase
    if (pos < 3'd6) r = txt[pos];
    else r = 8'h00;
    return r;
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] e);
    logic [2:0] r;
    case (e)
      ENT_AMP:  r = 3'd5;
      ENT_LT:   r = 3'd4;
      ENT_GT:   r = 3'd4;
      ENT_QUOT: r = 3'd6;
      ENT_APOS: r = 3'd6;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ent_char(input logic [2:0] e);
    logic [7:0] r;
    case (e)
      ENT_AMP:  r = 8'h26;
      ENT_LT:   r = 8'h3C;
      ENT_GT:   r = 8'h3E;
      ENT_QUOT: r = 8'h22;
      ENT_APOS: r = 8'h27;
      default:  r = 8'h00;
    endcase
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] dig_val(input logic [7:0] b, input logic hex);
    logic [4:0] r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (hex && (b inside {[8'h61:8'h66]})) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (hex && (b inside {[8'h41:8'h46]})) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
    logic [2:0] r;
    if (cp < CP_W'(32'h80)) r = 3'd1;
    else if (cp < CP_W'(32'h800)) r = 3'd2;
    else if (cp < CP_W'(32'h10000)) r = 3'd3;
    else r = 3'd4;
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (utf8_len(cp))
      3'd1: r = {1'b0, cp[6:0]};
      3'd2: begin
        case (idx)
          2'd0:    r = {3'b110, cp[10:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/xed_in_if.sv
// Input channel of the entity decoder: valid/ready plus one text byte item.
// Standalone; no package dependency.
`default_nettype none

interface xed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> rtl/xed_out_if.sv
// Output channel of the entity decoder: valid/ready plus one decoded result.
// Standalone; no package dependency.
`default_nettype none

interface xed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_in_run;
  logic       terminator;

  modport source (output valid, output out_byte, output last_in_run, output terminator,
                  input ready);
  modport sink   (input valid, input out_byte, input last_in_run, input terminator,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/xed_cp_unit.sv
// Code point accumulator: cp * base + digit, saturating at 21 bits.
// Depends on xed_pkg.
`default_nettype none

module xed_cp_unit (
  input  logic [xed_pkg::CP_W-1:0] cp_i,
  input  logic [3:0]               digit_i,
  input  logic                     hex_i,
  output logic [xed_pkg::CP_W-1:0] cp_o
);
  import xed_pkg::*;

  localparam int unsigned ACC_W = CP_W + 4;

  logic [ACC_W-1:0] scaled;
  logic [ACC_W-1:0] acc;

  always_comb begin
    // x10 as x8 + x2
    scaled = hex_i ? {cp_i, 4'b0000}
                   : ({1'b0, cp_i, 3'b000} + {3'b000, cp_i, 1'b0});
    acc    = scaled + ACC_W'(digit_i);
    cp_o   = (acc > ACC_W'(CP_MAX)) ? CP_MAX : acc[CP_W-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/xed_out_stage.sv
// Output stage: one-deep hold register plus output register. The held result
// is released when the next one arrives (not last) or at item end (last).
// Depends on xed_pkg and xed_out_if.
`default_nettype none

module xed_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xed_pkg::res_req_t req_i,
  output logic              step_ok_o,
  xed_out_if.source         out_o
);
  import xed_pkg::*;

  logic       hold_v_q, hold_v_d;
  logic [7:0] hold_data_q, hold_data_d;
  logic       hold_term_q, hold_term_d;
  logic       out_v_q, out_v_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_last_q, out_last_d;
  logic       out_term_q, out_term_d;
  logic       move;

  assign step_ok_o = !out_v_q || out_o.ready;

  always_comb begin
    move        = hold_v_q && (req_i.push || req_i.fin);
    out_v_d     = out_v_q && !out_o.ready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_term_d  = out_term_q;
    hold_v_d    = hold_v_q;
    hold_data_d = hold_data_q;
    hold_term_d = hold_term_q;
    if (move) begin
      out_v_d    = 1'b1;
      out_data_d = hold_data_q;
      out_last_d = req_i.fin;
      out_term_d = hold_term_q;
    end
    if (req_i.push) begin
      hold_v_d    = 1'b1;
      hold_data_d = req_i.data;
      hold_term_d = req_i.term;
    end else if (req_i.fin) begin
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_data_q <= hold_data_d;
    hold_term_q <= hold_term_d;
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
    out_term_q  <= out_term_d;
  end

  assign out_o.valid       = out_v_q;
  assign out_o.out_byte    = out_data_q;
  assign out_o.last_in_run = out_last_q;
  assign out_o.terminator  = out_term_q;

endmodule

`default_nettype wire

>>> rtl/xml_entity_decoder.sv
// A result is written to the hold register, then moves to the output register when
// the next result arrives or the item ends. A new item is taken only once the last
// one is finished; each result step also waits on output back-pressure.
// Reset: stream state cleared, limit 65535; pending byte store is not cleared.
`default_nettype none

module xml_entity_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [xed_pkg::LIM_W-1:0] cfg_wdata_i,
  xed_in_if.sink                    in_i,
  xed_out_if.source                 out_o
);
  import xed_pkg::*;

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [LIM_W-1:0]   limit_q;
  logic [7:0]         pend_q [MAX_REF_CHARS];
  logic               pend_we;
  logic [IDX_W-1:0]   pend_wa;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [NUM_ENT-1:0] cand_q, cand_d, ncand;
  logic [CP_W-1:0]    cp_q, cp_d, cp_acc;
  logic [LIM_W-1:0]   emit_q, emit_d;
  logic               stop_q, stop_d;
  logic [7:0]         b_q;
  logic               end_q;
  logic [2:0]         ulen_q, ulen_d, ulen_new;
  logic [1:0]         uidx_q, uidx_d;
  res_req_t           req;
  logic               step_ok;
  logic               acc;
  logic               hex_mode;
  logic [4:0]         dv;
  logic               room;
  logic               text_fits, utf_fits;
  logic [2:0]         hit_e;
  logic               hit_done;
  logic               fail, start_lit, emit_txt, store;
  logic [7:0]         txt_data;

  assign in_i.ready = (state_q == ST_IDLE) || ((state_q == ST_FIN) && step_ok);
  assign acc        = in_i.valid && in_i.ready;

  assign hex_mode  = (mode_q == MD_HEX) || (mode_q == MD_HEXMARK);
  assign dv        = dig_val(b_q, hex_mode);
  assign room      = cnt_q < CNT_W'(MAX_REF_CHARS);
  assign ulen_new  = utf8_len(cp_q);
  assign text_fits = ({1'b0, emit_q} + 17'd1) < {1'b0, limit_q};
  assign utf_fits  = ({2'b00, emit_q} + 18'(ulen_new) + 18'd1) <= {2'b00, limit_q};

  xed_cp_unit u_cp (
    .cp_i    (cp_q),
    .digit_i (dv[3:0]),
    .hex_i   (hex_mode),
    .cp_o    (cp_acc)
  );

  // named entity candidates that still match after this byte
  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      ncand[e] = cand_q[e] && (cnt_q < CNT_W'(ent_len(3'(e))))
                 && (ent_byte(3'(e), cnt_q[2:0]) == b_q);
    end
    hit_e = '0;
    for (int e = NUM_ENT - 1; e >= 0; e--) begin
      if (ncand[e]) hit_e = 3'(e);
    end
    hit_done = (cnt_q + CNT_W'(1)) == CNT_W'(ent_len(hit_e));
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    cand_d    = cand_q;
    cp_d      = cp_q;
    emit_d    = emit_q;
    stop_d    = stop_q;
    ulen_d    = ulen_q;
    uidx_d    = uidx_q;
    req       = '0;
    pend_we   = 1'b0;
    pend_wa   = cnt_q[IDX_W-1:0];
    fail      = 1'b0;
    start_lit = 1'b0;
    emit_txt  = 1'b0;
    store     = 1'b0;
    txt_data  = b_q;

    case (state_q)
      ST_IDLE: ;
      ST_DECIDE: begin
        if (step_ok) begin
          state_d = ST_FIN;
          if (stop_q) begin
            cnt_d  = '0;
            mode_d = MD_IDLE;
          end else begin
            case (mode_q)
              MD_IDLE: start_lit = 1'b1;
              MD_NAMED: begin
                if ((cnt_q == CNT_W'(1)) && (b_q == CH_HASH) && room) begin
                  store  = 1'b1;
                  mode_d = MD_HASH;
                end else if (|ncand) begin
                  if (hit_done) begin
                    emit_txt = 1'b1;
                    txt_data = ent_char(hit_e);
                    cnt_d    = '0;
                    mode_d   = MD_IDLE;
                  end else if (room) begin
                    store  = 1'b1;
                    cand_d = ncand;
                  end else begin
                    fail = 1'b1;
                  end
                end else begin
                  fail = 1'b1;
                end
              end
              MD_HASH: begin
                if (((b_q == CH_LX) || (b_q == CH_UX)) && room) begin
                  store  = 1'b1;
                  mode_d = MD_HEXMARK;
                end else if (dv[4] && room) begin
                  store  = 1'b1;
                  cp_d   = CP_W'(dv[3:0]);
                  mode_d = MD_DEC;
                end else begin
                  fail = 1'b1;
                end
              end
              MD_HEXMARK: begin
                if (dv[4] && room) begin
                  store  = 1'b1;
                  cp_d   = CP_W'(dv[3:0]);
                  mode_d = MD_HEX;
                end else begin
                  fail = 1'b1;
                end
              end
              MD_DEC, MD_HEX: begin
                if (b_q == CH_SEMI) begin
                  cnt_d  = '0;
                  mode_d = MD_IDLE;
                  if (utf_fits) begin
                    emit_d  = emit_q + LIM_W'(ulen_new);
                    ulen_d  = ulen_new;
                    uidx_d  = '0;
                    state_d = ST_UTF;
                  end else begin
                    stop_d = 1'b1;
                  end
                end else if (dv[4] && room) begin
                  store = 1'b1;
                  cp_d  = cp_acc;
                end else begin
                  fail = 1'b1;
                end
              end
              default: fail = 1'b1;
            endcase
          end
          if (fail) begin
            state_d = ST_FLUSH;
            k_d     = '0;
          end
        end
      end
      ST_FLUSH: begin
        if (step_ok) begin
          if (!stop_q && (k_q < cnt_q)) begin
            emit_txt = 1'b1;
            txt_data = pend_q[k_q[IDX_W-1:0]];
            k_d      = k_q + CNT_W'(1);
          end else begin
            cnt_d   = '0;
            mode_d  = MD_IDLE;
            state_d = end_q ? ST_TERM : ST_AFRESH;
          end
        end
      end
      ST_AFRESH: begin
        if (step_ok) begin
          start_lit = !stop_q;
          state_d   = ST_FIN;
        end
      end
      ST_UTF: begin
        if (step_ok) begin
          req.push = 1'b1;
          req.data = utf8_byte(cp_q, uidx_q);
          uidx_d   = uidx_q + 2'd1;
          if ((3'(uidx_q) + 3'd1) == ulen_q) state_d = ST_FIN;
        end
      end
      ST_TERM: begin
        if (step_ok) begin
          req.push = 1'b1;
          req.data = 8'h00;
          req.term = 1'b1;
          cnt_d    = '0;
          mode_d   = MD_IDLE;
          cp_d     = '0;
          emit_d   = '0;
          stop_d   = 1'b0;
          state_d  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (step_ok) begin
          req.fin = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // a byte with no reference open: '&' opens one, anything else is text
    if (start_lit) begin
      if (b_q == CH_AMP) begin
        pend_we = 1'b1;
        pend_wa = '0;
        cnt_d   = CNT_W'(1);
        mode_d  = MD_NAMED;
        cand_d  = '1;
      end else begin
        emit_txt = 1'b1;
      end
    end

    if (store) begin
      pend_we = 1'b1;
      cnt_d   = cnt_q + CNT_W'(1);
    end

    if (emit_txt) begin
      if (text_fits) begin
        req.push = 1'b1;
        req.data = txt_data;
        emit_d   = emit_q + LIM_W'(1);
      end else begin
        stop_d = 1'b1;
      end
    end

    if (acc) begin
      state_d = in_i.end_of_text ? ST_FLUSH : ST_DECIDE;
      k_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MD_IDLE;
      limit_q <= LIMIT_RST;
      cnt_q   <= '0;
      k_q     <= '0;
      cand_q  <= '0;
      cp_q    <= '0;
      emit_q  <= '0;
      stop_q  <= 1'b0;
      ulen_q  <= '0;
      uidx_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      cand_q  <= cand_d;
      cp_q    <= cp_d;
      emit_q  <= emit_d;
      stop_q  <= stop_d;
      ulen_q  <= ulen_d;
      uidx_q  <= uidx_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_q   <= in_i.text_byte;
      end_q <= in_i.end_of_text;
    end
    if (pend_we) pend_q[pend_wa] <= b_q;
  end

  xed_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .step_ok_o (step_ok),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/xed_checker.sv
// Port-level checks for xml_entity_decoder, attached by the bind below.
// Depends on the top level's interface ports only.
`default_nettype none

module xed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i,
  input logic       out_term_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_last_i) && $stable(out_term_i))
    else $error("output changed while stalled");

  // terminator closes its run and carries a zero byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_term_i |-> out_last_i && (out_byte_i == 8'h00))
    else $error("terminator not last or nonzero");

  // ready drops after an accepted item; an accepted item always needs more work
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after a transfer");

endmodule

bind xml_entity_decoder xed_checker u_xed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last_in_run),
  .out_term_i  (out_o.terminator)
);

`default_nettype wire
